// File: sv/min_heap_priority_queue_defines.svh
// Assertion macros shared by the heap queue RTL.
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mhpq_pkg.sv
package mhpq_pkg;

    localparam int KEY_W    = 32;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 48;

    // Operation codes carried in tuser on the input side.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEL_RD_POS,
        ST_DEL_RD_LAST,
        ST_DEL_GOT,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_START,
        ST_DN_L,
        ST_DN_R,
        ST_WR_KEY,
        ST_DONE
    } t_state;

endpackage

// File: sv/mhpq_ram.sv
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/min_heap_priority_queue.sv
// Channel    Direction  Payload
// s (in)     slave      tdata: key_in[31:0], position[42:32]; tuser: func[0]
// m (out)    master     tdata: key_out[31:0], count_out[42:32]; tuser: status[1:0]
//
// One operation at a time. During an insert's sift-up, the parent read and the
// compare-and-write overlap in the heap RAM, so each level needs a single ST_UP_CMP state.
// A delete's sift-down reads the two children in turn through the single read port.
// Refused operations go straight from ST_IDLE to ST_DONE.
// Reset (synchronous, active low) empties the heap; the RAM contents are not cleared.
// A stalled result sits in the output register; the next item may be taken meanwhile.
`include "min_heap_priority_queue_defines.svh"

module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // key_in[31:0], position[42:32], zero pad
    input  logic [0:0]        i_s_tuser,   // func[0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // key_out[31:0], count_out[42:32], zero pad
    output logic [1:0]        o_m_tuser    // status[1:0]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (IW > POS_W) ? IW : POS_W;

    t_state r_state, n_state;

    logic [CW-1:0]             r_count, n_count;
    logic [IW-1:0]             r_pos, n_pos;
    logic signed [KEY_W-1:0]   r_key, n_key;
    logic signed [KEY_W-1:0]   r_lkey, n_lkey;
    logic signed [KEY_W-1:0]   r_removed, n_removed;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic                      r_del, n_del;

    logic                      r_out_valid, n_out_valid;
    logic signed [KEY_W-1:0]   r_out_key;
    logic [STATUS_W-1:0]       r_out_status;
    logic [POS_W-1:0]          r_out_count;

    // Heap RAM controls, addressed by one-based heap index.
    logic                      w_we, w_re;
    logic [IW-1:0]             w_wr_idx, w_rd_idx;
    logic [IW-1:0]             w_wr_off, w_rd_off;
    logic [KEY_W-1:0]          w_wdata, w_rdata;
    logic signed [KEY_W-1:0]   w_rkey;

    // Input payload fields.
    logic                      w_in_func;
    logic signed [KEY_W-1:0]   w_in_key;
    logic [POS_W-1:0]          w_in_pos;
    logic [XW-1:0]             w_pos_x, w_cnt_x;
    logic                      w_full, w_del_bad, w_accept, w_out_free;

    // Heap index arithmetic.
    logic [IW-1:0]             w_cnt_i, w_par, w_gpar, w_lft, w_rgt;
    logic                      w_lft_ok, w_rgt_ok, w_up_swap, w_last_slot;
    logic [IW-1:0]             w_best_idx, w_best_child;
    logic signed [KEY_W-1:0]   w_best_key;
    logic                      w_best_moves, w_best_child_ok;
    logic [XW-1:0]             w_out_cnt_x;

    assign w_in_key  = i_s_tdata[KEY_W-1:0];
    assign w_in_pos  = i_s_tdata[KEY_W+POS_W-1:KEY_W];
    assign w_in_func = i_s_tuser[0];

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_pos_x   = XW'(w_in_pos);
    assign w_cnt_x   = XW'(r_count);
    assign w_full    = (r_count >= CW'(CAPACITY));
    assign w_del_bad = (w_pos_x == '0) || (w_pos_x > w_cnt_x);

    assign w_cnt_i      = IW'(r_count);
    assign w_par        = r_pos >> 1;
    assign w_gpar       = r_pos >> 2;
    assign w_lft        = r_pos << 1;
    assign w_rgt        = w_lft + IW'(1);
    assign w_lft_ok     = (w_lft <= w_cnt_i);
    assign w_rgt_ok     = (w_rgt <= w_cnt_i);
    assign w_rkey       = $signed(w_rdata);
    assign w_up_swap    = (w_rkey > r_key);
    assign w_last_slot  = (r_pos == w_cnt_i);

    // Smaller child against the moving key; the left child wins ties.
    always_comb begin
        w_best_idx = r_pos;
        w_best_key = r_key;
        if (r_lkey < w_best_key) begin
            w_best_idx = w_lft;
            w_best_key = r_lkey;
        end
        if (w_rgt_ok && (w_rkey < w_best_key)) begin
            w_best_idx = w_rgt;
            w_best_key = w_rkey;
        end
    end

    assign w_best_moves    = (w_best_idx != r_pos);
    assign w_best_child    = w_best_idx << 1;
    assign w_best_child_ok = (w_best_child <= w_cnt_i);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_in_func == FUNC_INSERT) begin
                        n_state = w_full ? ST_DONE : ST_UP_RD;
                    end else begin
                        n_state = w_del_bad ? ST_DONE : ST_DEL_RD_POS;
                    end
                end
            end
            ST_DEL_RD_POS:  n_state = ST_DEL_RD_LAST;
            ST_DEL_RD_LAST: n_state = ST_DEL_GOT;
            ST_DEL_GOT: begin
                n_state = w_last_slot ? ST_DONE : ST_UP_RD;
            end
            ST_UP_RD: begin
                if (r_pos == IW'(1)) begin
                    n_state = r_del ? ST_DN_START : ST_WR_KEY;
                end else begin
                    n_state = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (w_up_swap) begin
                    n_state = (w_par == IW'(1)) ? ST_WR_KEY : ST_UP_CMP;
                end else begin
                    n_state = r_del ? ST_DN_START : ST_WR_KEY;
                end
            end
            ST_DN_START: begin
                n_state = w_lft_ok ? ST_DN_L : ST_DONE;
            end
            ST_DN_L: n_state = ST_DN_R;
            ST_DN_R: begin
                if (!w_best_moves) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = w_best_child_ok ? ST_DN_L : ST_WR_KEY;
                end
            end
            ST_WR_KEY: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath updates and heap RAM accesses.
    always_comb begin
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_lkey      = r_lkey;
        n_removed   = r_removed;
        n_status    = r_status;
        n_del       = r_del;
        n_out_valid = r_out_valid && !i_m_tready;
        w_we        = 1'b0;
        w_wr_idx    = r_pos;
        w_wdata     = r_key;
        w_re        = 1'b0;
        w_rd_idx    = w_par;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_removed = '0;
                    n_status  = STATUS_OK;
                    n_key     = w_in_key;
                    if (w_in_func == FUNC_INSERT) begin
                        n_del = 1'b0;
                        if (w_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_pos   = IW'(r_count) + IW'(1);
                        end
                    end else begin
                        n_del = 1'b1;
                        n_pos = w_pos_x[IW-1:0];
                        if (w_del_bad) begin
                            n_status = STATUS_BAD;
                        end
                    end
                end
            end
            ST_DEL_RD_POS: begin
                w_re     = 1'b1;
                w_rd_idx = r_pos;
            end
            ST_DEL_RD_LAST: begin
                n_removed = w_rkey;
                w_re      = 1'b1;
                w_rd_idx  = w_cnt_i;
            end
            ST_DEL_GOT: begin
                n_key   = w_rkey;
                n_count = r_count - CW'(1);
            end
            ST_UP_RD: begin
                w_re     = (r_pos != IW'(1));
                w_rd_idx = w_par;
            end
            ST_UP_CMP: begin
                if (w_up_swap) begin
                    // Parent moves down into the hole; the hole climbs one level.
                    w_we     = 1'b1;
                    w_wr_idx = r_pos;
                    w_wdata  = w_rdata;
                    n_pos    = w_par;
                    n_del    = 1'b0;
                    w_re     = (w_par != IW'(1));
                    w_rd_idx = w_gpar;
                end
            end
            ST_DN_START: begin
                if (w_lft_ok) begin
                    w_re     = 1'b1;
                    w_rd_idx = w_lft;
                end else begin
                    w_we = 1'b1;
                end
            end
            ST_DN_L: begin
                n_lkey   = w_rkey;
                w_re     = w_rgt_ok;
                w_rd_idx = w_rgt;
            end
            ST_DN_R: begin
                w_we = 1'b1;
                if (w_best_moves) begin
                    // Smaller child moves up into the hole; the hole descends.
                    w_wdata  = w_best_key;
                    n_pos    = w_best_idx;
                    w_re     = w_best_child_ok;
                    w_rd_idx = w_best_child;
                end
            end
            ST_WR_KEY: begin
                w_we = 1'b1;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    assign w_wr_off = w_wr_idx - IW'(1);
    assign w_rd_off = w_rd_idx - IW'(1);
    assign w_out_cnt_x = XW'(r_count);

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_off[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_rd_off[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_lkey    <= n_lkey;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_del     <= n_del;
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_key    <= r_removed;
            r_out_status <= r_status;
            r_out_count  <= w_out_cnt_x[POS_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(DATA_W-KEY_W-POS_W){1'b0}}, r_out_count, r_out_key};
    assign o_m_tuser  = r_out_status;

    // Checks on the sequencer and the result register.
    `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "entry count above capacity")
    `MHPQ_ASSERT_NOW(a_write_phase, w_we, r_state == ST_UP_CMP || r_state == ST_DN_START || r_state == ST_DN_R || r_state == ST_WR_KEY, "heap write outside a sift")
    `MHPQ_ASSERT_NOW(a_refused_zero, o_m_tvalid && r_out_status != STATUS_OK, r_out_key == '0, "refused operation returned a key")
    `MHPQ_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != ST_IDLE, "accepted item left sequencer idle")

endmodule

// File: verif/mhpq_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the heap queue, keeps its own copy of the heap and
// checks every result transfer against the oldest outstanding prediction.
module mhpq_checker
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // key_in[31:0], position[42:32], zero pad
    input  logic [0:0]        i_s_tuser,   // func[0]
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [DATA_W-1:0] i_m_tdata,   // key_out[31:0], count_out[42:32], zero pad
    input  logic [1:0]        i_m_tuser,   // status[1:0]
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [STATUS_W-1:0]     status;
        logic [POS_W-1:0]        count;
    } t_heap_result;

    // Shadow heap, one-based like the block's own store.
    logic signed [KEY_W-1:0] heap_keys [1:HEAP_DEPTH];
    int                      keys_held;
    t_heap_result            awaited_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        keys_held    = 0;
    end

    function automatic void swap_slots(int a, int b);
        logic signed [KEY_W-1:0] tmp;
        tmp          = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endfunction

    // Move a key towards the root while its parent is strictly greater.
    function automatic void heap_sift_up(int p);
        while (p > 1 && heap_keys[p / 2] > heap_keys[p]) begin
            swap_slots(p, p / 2);
            p = p / 2;
        end
    endfunction

    // Move a key towards the leaves, taking the smaller child and the left one on ties.
    function automatic void heap_sift_down(int p);
        int   best;
        int   lc;
        logic done;
        done = 1'b0;
        while (!done) begin
            best = p;
            lc   = 2 * p;
            if (lc <= keys_held && heap_keys[lc] < heap_keys[best])
                best = lc;
            if (lc + 1 <= keys_held && heap_keys[lc + 1] < heap_keys[best])
                best = lc + 1;
            if (best == p) begin
                done = 1'b1;
            end else begin
                swap_slots(p, best);
                p = best;
            end
        end
    endfunction

    // Apply one operation to the shadow heap and return the result it should give.
    function automatic t_heap_result heap_apply(logic func, logic signed [KEY_W-1:0] key,
                                                int pos);
        t_heap_result res;
        res.key    = '0;
        res.status = STATUS_OK;
        if (func == FUNC_INSERT) begin
            if (keys_held >= HEAP_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                keys_held++;
                heap_keys[keys_held] = key;
                heap_sift_up(keys_held);
            end
        end else if (keys_held == 0 || pos < 1 || pos > keys_held) begin
            res.status = STATUS_BAD;
        end else begin
            res.key        = heap_keys[pos];
            heap_keys[pos] = heap_keys[keys_held];
            keys_held--;
            // Removing the last slot needs no repair at all.
            if (pos <= keys_held) begin
                if (pos > 1 && heap_keys[pos] < heap_keys[pos / 2])
                    heap_sift_up(pos);
                else
                    heap_sift_down(pos);
            end
        end
        res.count = POS_W'(keys_held);
        return res;
    endfunction

    function automatic void check_field(string label, longint expv, longint actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, expv, actv);
            o_fail_count++;
        end
    endfunction

    // Results are compared before new predictions are queued, so that a result
    // arriving with nothing outstanding is never paired with the newest item.
    always @(posedge i_clk) begin
        t_heap_result exp_res;
        if (!i_rst_n) begin
            keys_held = 0;
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, key_out %0d status %0d count_out %0d",
                             $time, $signed(i_m_tdata[KEY_W-1:0]), i_m_tuser,
                             i_m_tdata[KEY_W+POS_W-1:KEY_W]);
                    o_fail_count++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    check_field("key_out", longint'($signed(exp_res.key)),
                                longint'($signed(i_m_tdata[KEY_W-1:0])));
                    check_field("status", longint'(exp_res.status), longint'(i_m_tuser));
                    check_field("count_out", longint'(exp_res.count),
                                longint'(i_m_tdata[KEY_W+POS_W-1:KEY_W]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(heap_apply(i_s_tuser[0], i_s_tdata[KEY_W-1:0],
                                                     int'(i_s_tdata[KEY_W+POS_W-1:KEY_W])));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Drives operations into the heap queue, throttles the result side and gives the verdict.
module tb_top;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH     = 1024;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 5000;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata  = '0;   // key_in[31:0], position[42:32], zero pad
    logic [0:0]        i_s_tuser  = '0;   // func[0]
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;         // key_out[31:0], count_out[42:32], zero pad
    logic [1:0]        o_m_tuser;         // status[1:0]

    int   fail_count;
    int   pending;
    int   held_keys   = 0;
    int   idle_cycles = 0;
    logic tx_burst    = 1'b0;
    logic rx_burst    = 1'b0;
    logic rx_hold_req = 1'b0;

    min_heap_priority_queue #(
        .CAPACITY (HEAP_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    mhpq_checker #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_heap_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // The run is abandoned when neither channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: random back-pressure, calm stretches and one long hold on request.
    initial begin
        int   rx_left;
        int   r;
        logic hold_done;
        rx_left   = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                rx_left   = LONG_HOLD;
            end
            if ($urandom_range(0, 99) < 2)
                rx_burst = ~rx_burst;
            if (rx_left > 0) begin
                rx_left--;
                i_m_tready <= 1'b0;
            end else if (rx_burst) begin
                i_m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_m_tready <= 1'b1;
                end else if (r < 95) begin
                    i_m_tready <= 1'b0;
                    rx_left    = $urandom_range(0, 3);
                end else begin
                    i_m_tready <= 1'b0;
                    rx_left    = $urandom_range(10, 40);
                end
            end
        end
    end

    // Gap after each input transfer: mostly none or short, now and then long.
    function automatic int sender_gap();
        int r;
        if ($urandom_range(0, 99) < 3)
            tx_burst = ~tx_burst;
        if (tx_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Keys lean towards extremes and a narrow band, so that ties are common.
    function automatic logic [KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 4)
            return KEY_W'(int'($urandom_range(0, 64)) - 32);
        return $urandom;
    endfunction

    // Delete positions are mostly valid, with the root, the last slot and bad ones mixed in.
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        if (held_keys == 0)
            return POS_W'($urandom_range(0, 2047));
        r = $urandom_range(0, 99);
        if (r < 80)
            return POS_W'($urandom_range(1, held_keys));
        if (r < 86)
            return POS_W'(1);
        if (r < 92)
            return POS_W'(held_keys);
        if (r < 96)
            return POS_W'(0);
        return POS_W'($urandom_range(held_keys + 1, 2047));
    endfunction

    // One input transfer, followed by a random gap; returns aligned to a rising edge.
    task automatic send_op(input logic func, input logic [KEY_W-1:0] key,
                           input logic [POS_W-1:0] pos);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(DATA_W-KEY_W-POS_W){1'b0}}, pos, key};
        i_s_tuser  <= func;
        do @(posedge i_clk); while (!o_s_tready);
        // Track occupancy only to steer the choice of positions.
        if (func == FUNC_INSERT && held_keys < HEAP_DEPTH)
            held_keys++;
        else if (func == FUNC_DELETE && pos >= 1 && pos <= held_keys)
            held_keys--;
        gap = sender_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue_random(input int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            send_op(FUNC_INSERT, rand_key(), POS_W'($urandom));
        else
            send_op(FUNC_DELETE, rand_key(), pick_position());
    endtask

    // Stop offering items until every outstanding result has been taken.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Deletes on an empty heap are refused.
        send_op(FUNC_DELETE, 32'h0000_0000, 11'd1);
        send_op(FUNC_DELETE, 32'hFFFF_FFFF, 11'd0);
        // Build 1 10 2 11 12 3 4; removing slot 4 pulls the last key up past its parent.
        send_op(FUNC_INSERT, 32'd1, 11'd0);
        send_op(FUNC_INSERT, 32'd10, 11'h7FF);
        send_op(FUNC_INSERT, 32'd2, 11'd0);
        send_op(FUNC_INSERT, 32'd11, 11'd0);
        send_op(FUNC_INSERT, 32'd12, 11'd0);
        send_op(FUNC_INSERT, 32'd3, 11'd0);
        send_op(FUNC_INSERT, 32'd4, 11'd0);
        send_op(FUNC_DELETE, 32'd0, 11'd4);
        send_op(FUNC_DELETE, 32'd0, 11'd1);
        // Extreme keys and duplicates.
        send_op(FUNC_INSERT, 32'h7FFF_FFFF, 11'd0);
        send_op(FUNC_INSERT, 32'h8000_0000, 11'd0);
        send_op(FUNC_INSERT, 32'hFFFF_FFFF, 11'd0);
        send_op(FUNC_INSERT, 32'h7FFF_FFFF, 11'd0);
        send_op(FUNC_INSERT, 32'h0000_0000, 11'd0);
        // Bad positions: zero, one past the end, the top of the field and the capacity.
        send_op(FUNC_DELETE, 32'd0, 11'd0);
        send_op(FUNC_DELETE, 32'd0, POS_W'(held_keys + 1));
        send_op(FUNC_DELETE, 32'd0, 11'h7FF);
        send_op(FUNC_DELETE, 32'd0, 11'd1024);
        // The last slot goes without any sift, then the middle and the root.
        send_op(FUNC_DELETE, 32'd0, POS_W'(held_keys));
        send_op(FUNC_DELETE, 32'd0, 11'd3);
        send_op(FUNC_DELETE, 32'd0, 11'd2);
        send_op(FUNC_DELETE, 32'd0, 11'd1);

        // Mixed traffic, with a long hold on the result side part-way through.
        repeat (100) issue_random(60);
        rx_hold_req = 1'b1;
        repeat (150) issue_random(60);
        wait_drained();

        // Fill to capacity, then hammer the full heap.
        while (held_keys < HEAP_DEPTH)
            issue_random(95);
        repeat (25) issue_random(85);
        wait_drained();

        // Mostly deletes from a deep heap.
        repeat (300) issue_random(15);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
